/* rtl/core/olc_pkg.sv */
package olc_pkg;

	// Default number of entries the list storage holds.
	localparam int DEPTH_DEF = 16;

	// Field widths of the channels and the capacity register.
	localparam int MODE_W = 3;
	localparam int POS_W  = 4;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 5;
	localparam int ORD_W  = 2;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE_LAST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE_AT   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ        = 3'd4;

	// Order class codes.
	localparam logic [ORD_W-1:0] ORD_NONE = 2'd0;
	localparam logic [ORD_W-1:0] ORD_ASC  = 2'd1;
	localparam logic [ORD_W-1:0] ORD_DESC = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // capture the accepted item
		logic exec;         // apply the operation to the list
		logic compare;      // register the neighbor comparisons
		logic result_load;  // fill the output register
	} olc_cmd_t;

endpackage

/* rtl/core/olc_in_if.sv */
interface olc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [olc_pkg::MODE_W-1:0]            mode;
	logic [olc_pkg::POS_W-1:0]             position;
	logic signed [olc_pkg::WORD_W-1:0]     data_word;

	modport source(output valid, mode, position, data_word, input ready);
	modport sink(input valid, mode, position, data_word, output ready);
endinterface

/* rtl/core/olc_out_if.sv */
interface olc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  ok;
	logic signed [olc_pkg::WORD_W-1:0]     read_word;
	logic [olc_pkg::CNT_W-1:0]             entry_count;
	logic [olc_pkg::ORD_W-1:0]             order_class;

	modport source(output valid, ok, read_word, entry_count, order_class, input ready);
	modport sink(input valid, ok, read_word, entry_count, order_class, output ready);
endinterface

/* rtl/core/olc_ctrl.sv */
module olc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output olc_pkg::olc_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.load        = in_valid && (state_q == S_IDLE);
		cmd.exec        = (state_q == S_EXEC);
		cmd.compare     = (state_q == S_CMP);
		cmd.result_load = (state_q == S_DONE) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_CMP;
			S_CMP:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/olc_dpath.sv */
module olc_dpath #(
	parameter int DEPTH = olc_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  olc_pkg::olc_cmd_t                  cmd,
	input  logic                               cfg_we,
	input  logic [olc_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic [olc_pkg::MODE_W-1:0]         in_mode,
	input  logic [olc_pkg::POS_W-1:0]          in_position,
	input  logic signed [olc_pkg::WORD_W-1:0]  in_data,
	output logic                               out_ok,
	output logic signed [olc_pkg::WORD_W-1:0]  out_read_word,
	output logic [olc_pkg::CNT_W-1:0]          out_entry_count,
	output logic [olc_pkg::ORD_W-1:0]          out_order_class
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > olc_pkg::CAP_W) ? CW : olc_pkg::CAP_W;

	// Captured item.
	logic [olc_pkg::MODE_W-1:0]        mode_q;
	logic [olc_pkg::POS_W-1:0]         pos_q;
	logic signed [olc_pkg::WORD_W-1:0] data_q;

	// List state and capacity register.
	logic signed [olc_pkg::WORD_W-1:0] entries_q [DEPTH];
	logic signed [olc_pkg::WORD_W-1:0] ent_d     [DEPTH];
	logic [CW-1:0]                     count_q;
	logic [olc_pkg::CAP_W-1:0]         cap_q;

	// Step results and neighbor comparison flags.
	logic                              ok_q;
	logic signed [olc_pkg::WORD_W-1:0] rd_q;
	logic [DEPTH-2:0]                  up_d, dn_d, up_q, dn_q, pair_mask;

	// Output register.
	logic                              out_ok_q;
	logic signed [olc_pkg::WORD_W-1:0] out_rd_q;
	logic [olc_pkg::CNT_W-1:0]         out_cnt_q;
	logic [olc_pkg::ORD_W-1:0]         out_ord_q;

	logic [XW-1:0]                     count_x, pos_x, cap_x;
	logic                              room, ok_c, grow, shrink, gives_word;
	logic [AW-1:0]                     raddr;
	logic signed [olc_pkg::WORD_W-1:0] rd_c;
	logic                              all_up, all_dn;

	assign count_x = XW'(count_q);
	assign pos_x   = XW'(pos_q);
	assign cap_x   = XW'(cap_q);
	assign room    = (count_x < cap_x) && (count_q < CW'(DEPTH));

	always_comb begin
		ok_c       = 1'b0;
		grow       = 1'b0;
		shrink     = 1'b0;
		gives_word = 1'b0;
		unique case (mode_q)
			olc_pkg::MODE_APPEND: begin
				ok_c = room;
				grow = room;
			end
			olc_pkg::MODE_INSERT: begin
				ok_c = room && (pos_x <= count_x);
				grow = ok_c;
			end
			olc_pkg::MODE_REMOVE_LAST: begin
				ok_c       = (count_q != '0);
				shrink     = ok_c;
				gives_word = ok_c;
			end
			olc_pkg::MODE_REMOVE_AT: begin
				ok_c       = (pos_x < count_x);
				shrink     = ok_c;
				gives_word = ok_c;
			end
			olc_pkg::MODE_READ: begin
				ok_c       = (pos_x < count_x);
				gives_word = ok_c;
			end
			default: ok_c = 1'b0;
		endcase
	end

	// Removing the last entry reads the top of the list, everything else reads at the position.
	assign raddr = (mode_q == olc_pkg::MODE_REMOVE_LAST) ? AW'(count_q - 1'b1) : AW'(pos_x);
	assign rd_c  = gives_word ? entries_q[raddr] : '0;

	// Each entry takes the new word, its lower or upper neighbor, or holds.
	for (genvar i = 0; i < DEPTH; i++) begin : g_ent
		localparam logic [XW-1:0] IDX = XW'(i);
		logic signed [olc_pkg::WORD_W-1:0] prev_w, next_w;
		if (i > 0) begin : g_prev
			assign prev_w = entries_q[i-1];
		end else begin : g_prev0
			assign prev_w = data_q;
		end
		if (i < DEPTH - 1) begin : g_next
			assign next_w = entries_q[i+1];
		end else begin : g_next0
			assign next_w = data_q;
		end
		assign ent_d[i] =
			(mode_q == olc_pkg::MODE_APPEND && IDX == count_x) ? data_q :
			(mode_q == olc_pkg::MODE_INSERT && IDX == pos_x)   ? data_q :
			(mode_q == olc_pkg::MODE_INSERT && IDX > pos_x && IDX <= count_x) ? prev_w :
			(mode_q == olc_pkg::MODE_REMOVE_AT && IDX >= pos_x
				&& (IDX + 1'b1) < count_x) ? next_w :
			entries_q[i];
	end

	// Neighbor pair i sits between entries i and i+1 and counts only inside the list.
	for (genvar i = 0; i < DEPTH - 1; i++) begin : g_pair
		localparam logic [XW-1:0] HI = XW'(i + 1);
		assign up_d[i]      = entries_q[i] < entries_q[i+1];
		assign dn_d[i]      = entries_q[i+1] < entries_q[i];
		assign pair_mask[i] = HI < count_x;
	end

	assign all_up = &(up_q | ~pair_mask);
	assign all_dn = &(dn_q | ~pair_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= olc_pkg::CAP_RESET;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.exec) begin
				if (grow) begin
					count_q <= count_q + 1'b1;
				end else if (shrink) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			pos_q  <= in_position;
			data_q <= in_data;
		end
		if (cmd.exec) begin
			ok_q <= ok_c;
			rd_q <= rd_c;
			if (ok_c) entries_q <= ent_d;
		end
		if (cmd.compare) begin
			up_q <= up_d;
			dn_q <= dn_d;
		end
		if (cmd.result_load) begin
			out_ok_q  <= ok_q;
			out_rd_q  <= rd_q;
			out_cnt_q <= olc_pkg::CNT_W'(count_q);
			out_ord_q <= all_up ? olc_pkg::ORD_ASC :
				all_dn ? olc_pkg::ORD_DESC : olc_pkg::ORD_NONE;
		end
	end

	assign out_ok          = out_ok_q;
	assign out_read_word   = out_rd_q;
	assign out_entry_count = out_cnt_q;
	assign out_order_class = out_ord_q;

endmodule

/* rtl/core/ordered_list_with_order_check_core.sv */
// Ordered list with order check: a list of up to DEPTH signed 32-bit words.
// Each item on in_ch names one operation: append, insert at a position,
// remove the last entry, remove at a position, or read at a position. Each
// item yields exactly one result item on out_ch with ok, the word read or
// removed (zero otherwise), the entry count and the order class of the list
// after the step (strictly ascending, strictly descending or unordered).
// The capacity register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce. The capacity in effect is the smaller of it and DEPTH.
// Results come from the output register. The controller walks one item
// through capture, execute, compare and result stages and takes no new item
// until the last one has left the result stage.
// The next item is accepted while a result still sits in the output
// register; if the receiver stalls, the following result waits in the
// datapath until the output register is free, and in_ch stops accepting.
// Reset empties the list and sets the capacity register to 16; entries that
// were never written hold no defined value but are never read.
module ordered_list_with_order_check_core #(
	parameter int DEPTH = olc_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [olc_pkg::CAP_W-1:0] cfg_wdata,
	olc_in_if.sink                    in_ch,
	olc_out_if.source                 out_ch
);

	// Command bundle from the controller to the datapath.
	olc_pkg::olc_cmd_t cmd;

	// The controller sequences each item and owns both handshakes.
	olc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// The datapath holds the list, the capacity register and the output register.
	olc_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_mode         (in_ch.mode),
		.in_position     (in_ch.position),
		.in_data         (in_ch.data_word),
		.out_ok          (out_ch.ok),
		.out_read_word   (out_ch.read_word),
		.out_entry_count (out_ch.entry_count),
		.out_order_class (out_ch.order_class)
	);

	// Only one item is in flight, so an accept always drops ready for the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted while an item is still being processed");

	// A refused operation never returns a word.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ok |-> out_ch.read_word == '0)
		else $error("refused operation returned a nonzero word");

	// An empty list always reports ascending order.
	a_empty_asc: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.entry_count == '0 |-> out_ch.order_class == olc_pkg::ORD_ASC)
		else $error("empty list reported an order other than ascending");

	// A new result appears only after the controller has been through its result stage.
	a_result_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(!in_ch.ready))
		else $error("result appeared without an item in progress");

endmodule

/* sim/olc_list_checker.sv */
module olc_list_checker
	import olc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	olc_in_if                in_mon,
	olc_out_if               out_mon,
	output int               fail_count,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] word;
		logic [CNT_W-1:0]         count;
		logic [ORD_W-1:0]         order;
	} list_result_t;

	// Shadow copy of the list, its length and the capacity register.
	logic signed [WORD_W-1:0] list_words [DEPTH];
	int unsigned              list_len;
	logic [CAP_W-1:0]         cap_setting;
	list_result_t             expected_q [$];

	// Applies one operation to the shadow list and returns the result it should give.
	function automatic list_result_t step_list(input logic [MODE_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [WORD_W-1:0] word);
		list_result_t res;
		int unsigned  room;
		int           idx;
		logic         rising;
		logic         falling;
		res = '0;
		room = (cap_setting < DEPTH) ? cap_setting : DEPTH;
		case (op)
			MODE_APPEND: begin
				if (list_len < room) begin
					list_words[list_len] = word;
					list_len++;
					res.ok = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (list_len < room && pos <= list_len) begin
					for (idx = list_len; idx > pos; idx--)
						list_words[idx] = list_words[idx-1];
					list_words[pos] = word;
					list_len++;
					res.ok = 1'b1;
				end
			end
			MODE_REMOVE_LAST: begin
				if (list_len > 0) begin
					list_len--;
					res.word = list_words[list_len];
					res.ok = 1'b1;
				end
			end
			MODE_REMOVE_AT: begin
				if (pos < list_len) begin
					res.word = list_words[pos];
					for (idx = pos; idx + 1 < list_len; idx++)
						list_words[idx] = list_words[idx+1];
					list_len--;
					res.ok = 1'b1;
				end
			end
			MODE_READ: begin
				if (pos < list_len) begin
					res.word = list_words[pos];
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		// Equal neighbors spoil both directions; empty and single lists count as rising.
		rising = 1'b1;
		falling = 1'b1;
		for (idx = 1; idx < list_len; idx++) begin
			if (!(list_words[idx-1] < list_words[idx]))
				rising = 1'b0;
			if (!(list_words[idx] < list_words[idx-1]))
				falling = 1'b0;
		end
		res.count = list_len[CNT_W-1:0];
		res.order = rising ? ORD_ASC : (falling ? ORD_DESC : ORD_NONE);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t seen;
		list_result_t want;
		if (!arst_n) begin
			expected_q.delete();
			list_len = 0;
			cap_setting = CAP_RESET;
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				cap_setting = cfg_wdata;
			if (out_mon.valid && out_mon.ready) begin
				seen.ok = out_mon.ok;
				seen.word = out_mon.read_word;
				seen.count = out_mon.entry_count;
				seen.order = out_mon.order_class;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with nothing expected: ok=%0d word=%0d count=%0d order=%0d",
							$time, seen.ok, seen.word, seen.count, seen.order);
				end else begin
					want = expected_q.pop_front();
					if (seen.ok !== want.ok || seen.word !== want.word ||
							seen.count !== want.count || seen.order !== want.order) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch: expected ok=%0d word=%0d count=%0d order=%0d, got ok=%0d word=%0d count=%0d order=%0d",
								$time, want.ok, want.word, want.count, want.order,
								seen.ok, seen.word, seen.count, seen.order);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_q.push_back(step_list(in_mon.mode, in_mon.position, in_mon.data_word));
			outstanding = expected_q.size();
		end
	end

endmodule

/* sim/ordered_list_with_order_check_core_tb.sv */
module ordered_list_with_order_check_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import olc_pkg::*;

	// Mode codes above the last operation are unknown and must be refused.
	localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = MODE_READ + 3'd1;
	localparam logic [MODE_W-1:0] MODE_LAST_CODE    = {MODE_W{1'b1}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

	// Operation mixes and data shapes used by the random phases.
	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_e;
	typedef enum int {DATA_RANDOM, DATA_SMALL, DATA_RISING, DATA_FALLING} data_shape_e;

	typedef struct {
		logic [CAP_W-1:0] capacity;
		op_mix_e          mix;
		data_shape_e      shape;
		int               items;
		int               max_gap;
	} phase_t;

	// Each row gives the cumulative percentage for append, insert, read,
	// remove last and remove at; the remainder goes to unknown modes.
	int unsigned mix_bounds [3][5] = '{
		'{55, 80, 87, 92, 96},
		'{22, 44, 60, 75, 95},
		'{ 8, 14, 34, 62, 97}
	};

	// The phases run through the capacity extremes, a capacity lowered below
	// the current length, zero capacity and a capacity above the storage size.
	phase_t test_plan [13] = '{
		'{5'd16, MIX_FILL,     DATA_RANDOM,  150, 3},
		'{5'd4,  MIX_BALANCED, DATA_RANDOM,  120, 6},
		'{5'd0,  MIX_BALANCED, DATA_SMALL,   100, 2},
		'{5'd31, MIX_FILL,     DATA_RISING,  150, 0},
		'{5'd31, MIX_DRAIN,    DATA_RANDOM,  120, 5},
		'{5'd1,  MIX_BALANCED, DATA_SMALL,   120, 3},
		'{5'd16, MIX_FILL,     DATA_FALLING, 150, 1},
		'{5'd17, MIX_BALANCED, DATA_SMALL,   200, 4},
		'{5'd2,  MIX_DRAIN,    DATA_RANDOM,  120, 6},
		'{5'd8,  MIX_FILL,     DATA_SMALL,   150, 2},
		'{5'd16, MIX_BALANCED, DATA_RANDOM,  250, 0},
		'{5'd5,  MIX_BALANCED, DATA_RISING,  150, 3},
		'{5'd16, MIX_DRAIN,    DATA_RANDOM,  150, 4}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               mismatch_total;
	int               results_due;

	// Running value for the rising and falling data shapes.
	logic signed [WORD_W-1:0] ramp_word = '0;

	// Receiver stall state: a style is held for a span of cycles, and the
	// long-stall style counts down its own hold.
	int rx_style = 0;
	int rx_span  = 0;
	int rx_hold  = 0;

	olc_in_if  in_ch();
	olc_out_if out_ch();

	ordered_list_with_order_check_core #(
		.DEPTH(DEPTH_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// The checker mirrors the list from the accepted items and compares
	// every result; it hands back the failure count and the number of
	// results still due.
	olc_list_checker #(
		.DEPTH(DEPTH_DEF)
	) u_list_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.fail_count (mismatch_total),
		.outstanding(results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver picks a stall style for a random span: always ready,
	// mostly ready, ready one cycle in four, or long stalls with a single
	// ready cycle between them.
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_span = $urandom_range(20, 120);
		end
		rx_span--;
		case (rx_style)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 9) < 7);
			2: out_ch.ready <= (rx_span % 4 == 0);
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					out_ch.ready <= 1'b0;
				end else begin
					rx_hold = $urandom_range(0, 20);
					out_ch.ready <= 1'b1;
				end
			end
		endcase
	end

	// Presents one item at the falling edge and returns at the rising edge
	// that accepts it. Valid stays high if the next call follows at once.
	task automatic send_item(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [WORD_W-1:0] word);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.mode <= op;
		in_ch.position <= pos;
		in_ch.data_word <= word;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
	endtask

	// Drops valid and waits until every expected result has come back, then
	// lets the pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The capacity register is only written while the block is idle.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends items in bursts of random length, drawn from the phase's
	// operation mix and data shape, with random gaps between bursts and now
	// and then a full drain before the next burst.
	task automatic run_phase(input phase_t ph);
		int                       sent;
		int                       burst;
		int unsigned              roll;
		logic [MODE_W-1:0]        op;
		logic [POS_W-1:0]         pos;
		logic signed [WORD_W-1:0] word;
		sent = 0;
		while (sent < ph.items) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < mix_bounds[ph.mix][0])
					op = MODE_APPEND;
				else if (roll < mix_bounds[ph.mix][1])
					op = MODE_INSERT;
				else if (roll < mix_bounds[ph.mix][2])
					op = MODE_READ;
				else if (roll < mix_bounds[ph.mix][3])
					op = MODE_REMOVE_LAST;
				else if (roll < mix_bounds[ph.mix][4])
					op = MODE_REMOVE_AT;
				else
					op = MODE_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_CODE));
				// Half the positions favor the head of the list, where they
				// are valid even for short lists.
				if ($urandom_range(0, 1) == 0)
					pos = POS_W'($urandom_range(0, 15));
				else
					pos = POS_W'($urandom_range(0, 3));
				case (ph.shape)
					DATA_SMALL: word = WORD_W'($signed($urandom_range(0, 6)) - 3);
					DATA_RISING: begin
						ramp_word = ramp_word + WORD_W'($urandom_range(1, 1000));
						word = ramp_word;
					end
					DATA_FALLING: begin
						ramp_word = ramp_word - WORD_W'($urandom_range(1, 1000));
						word = ramp_word;
					end
					default: begin
						case ($urandom_range(0, 15))
							0: word = WORD_MIN;
							1: word = WORD_MAX;
							default: word = $urandom;
						endcase
					end
				endcase
				send_item(op, pos, word);
				sent++;
			end
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			else
				hold_off($urandom_range(0, ph.max_gap));
		end
	endtask

	// Stimulus: reset, a directed pass over the special cases, then the
	// random phases, each under its own capacity setting.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_APPEND;
		in_ch.position = '0;
		in_ch.data_word = '0;
		out_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed pass at the reset capacity. An empty list refuses both
		// removals, a read and an insert past its end.
		send_item(MODE_REMOVE_LAST, 4'd0, '0);
		send_item(MODE_REMOVE_AT, 4'd0, '0);
		send_item(MODE_READ, 4'd0, '0);
		send_item(MODE_INSERT, 4'd1, 32'sd7);
		// Build the extremes of the word range and break the order.
		send_item(MODE_INSERT, 4'd0, WORD_MIN);
		send_item(MODE_APPEND, 4'd0, WORD_MAX);
		send_item(MODE_APPEND, 4'd15, -32'sd1);
		send_item(MODE_READ, 4'd2, '0);
		send_item(MODE_READ, 4'd3, '0);
		send_item(MODE_REMOVE_AT, 4'd1, '0);
		send_item(MODE_INSERT, 4'd0, '0);
		// Insert at the position equal to the length appends.
		send_item(MODE_INSERT, 4'd3, 32'sd5);
		send_item(MODE_REMOVE_LAST, 4'd0, '0);
		// Unknown modes change nothing.
		for (int extra = 0; extra < 3; extra++)
			send_item(MODE_FIRST_UNUSED + MODE_W'(extra), 4'd15, -32'sd1);
		// Two equal neighbors make the list unordered.
		send_item(MODE_APPEND, 4'd0, -32'sd1);
		send_item(MODE_REMOVE_AT, 4'd0, '0);
		send_item(MODE_REMOVE_LAST, 4'd0, '0);
		send_item(MODE_REMOVE_AT, 4'd1, '0);
		send_item(MODE_REMOVE_LAST, 4'd0, '0);
		// A falling pair, then a read at the highest position.
		send_item(MODE_APPEND, 4'd0, 32'sd10);
		send_item(MODE_APPEND, 4'd0, 32'sd5);
		send_item(MODE_READ, 4'd15, '0);

		foreach (test_plan[i]) begin
			write_capacity(test_plan[i].capacity);
			run_phase(test_plan[i]);
		end

		// Every result must be in before the verdict.
		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatch_total == 0 && results_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// A correct run needs well under a tenth of this.
	initial begin
		#(10_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/olc_pkg.sv
rtl/core/olc_in_if.sv
rtl/core/olc_out_if.sv
rtl/core/olc_ctrl.sv
rtl/core/olc_dpath.sv
rtl/core/ordered_list_with_order_check_core.sv
sim/olc_list_checker.sv
sim/ordered_list_with_order_check_core_tb.sv
